/* sv/dpm_pkg.sv */
// ----------------------------------------------------------------------------
// dpm_pkg
// shared types and constants for the display power-mode controller
// ----------------------------------------------------------------------------
package dpm_pkg;

    // power modes, also the state encoding of the mode register
    typedef enum logic [1:0] {
        MODE_ACTIVE = 2'd0,
        MODE_ONLINE = 2'd1,
        MODE_DEEP   = 2'd2
    } t_dpm_mode;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_NOTIFY     = 2'd1,
        CMD_DEEP_ENTER = 2'd2,
        CMD_DEEP_LEAVE = 2'd3
    } t_dpm_cmd;

    typedef enum logic [1:0] {
        WAKE_NONE   = 2'd0,
        WAKE_KEY    = 2'd1,
        WAKE_MOTION = 2'd2,
        WAKE_NOTIFY = 2'd3
    } t_dpm_wake;

    typedef enum logic [2:0] {
        CFG_MOTION_EN   = 3'd0,
        CFG_MOTION_THR  = 3'd1,
        CFG_MOTION_COOL = 3'd2,
        CFG_DISP_TMO    = 3'd3,
        CFG_WAKE_ERR    = 3'd4,
        CFG_WAKE_WARN   = 3'd5
    } t_dpm_cfg_idx;

    localparam logic [1:0] LVL_WARN  = 2'd1;
    localparam logic [1:0] LVL_ERROR = 2'd2;

    localparam logic [9:0] MOTION_WINDOW_MS = 10'd750;
    localparam logic [1:0] MOTION_SAMPLES   = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef struct packed {
        logic        motion_en;
        logic [15:0] motion_thr;
        logic [31:0] motion_cool;
        logic [31:0] disp_tmo;
        logic        wake_err;
        logic        wake_warn;
    } t_dpm_cfg;

    // event fields other than the timestamp
    typedef struct packed {
        t_dpm_cmd    command;
        logic        key_activity;
        logic [15:0] motion_delta;
        logic [1:0]  notify_level;
        logic        quiet_mode;
    } t_dpm_evt;

    typedef struct packed {
        logic      disp_on;
        logic      disp_off;
        logic      sleep_enter;
        logic      sleep_exit;
        logic      sound_req;
        t_dpm_wake wake_src;
        t_dpm_mode current_mode;
    } t_dpm_res;

endpackage

/* sv/dpm_evt_if.sv */
// ----------------------------------------------------------------------------
// dpm_evt_if
// event channel: valid/ready with the event fields
// ----------------------------------------------------------------------------
interface dpm_evt_if #(
    parameter int TIME_WIDTH = 48
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            command;
    logic [TIME_WIDTH-1:0] timestamp;
    logic                  key_activity;
    logic [15:0]           motion_delta;
    logic [1:0]            notify_level;
    logic                  quiet_mode;

    modport source (
        output valid, command, timestamp, key_activity, motion_delta, notify_level,
               quiet_mode,
        input  ready
    );

    modport sink (
        input  valid, command, timestamp, key_activity, motion_delta, notify_level,
               quiet_mode,
        output ready
    );
endinterface

/* sv/dpm_res_if.sv */
// ----------------------------------------------------------------------------
// dpm_res_if
// result channel: valid/ready with the action flags
// ----------------------------------------------------------------------------
interface dpm_res_if;
    logic       valid;
    logic       ready;
    logic       disp_on;
    logic       disp_off;
    logic       sleep_enter;
    logic       sleep_exit;
    logic       sound_req;
    logic [1:0] wake_src;
    logic [1:0] current_mode;

    modport source (
        output valid, disp_on, disp_off, sleep_enter, sleep_exit,
               sound_req, wake_src, current_mode,
        input  ready
    );

    modport sink (
        input  valid, disp_on, disp_off, sleep_enter, sleep_exit,
               sound_req, wake_src, current_mode,
        output ready
    );
endinterface

/* sv/dpm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dpm_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module dpm_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dpm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dpm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output dpm_pkg::t_dpm_cfg               o_cfg
);
    import dpm_pkg::*;

    t_dpm_cfg r_cfg;
    t_dpm_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MOTION_EN:   n_cfg.motion_en   = i_cfg_data[0];
                CFG_MOTION_THR:  n_cfg.motion_thr  = i_cfg_data[15:0];
                CFG_MOTION_COOL: n_cfg.motion_cool = i_cfg_data[31:0];
                CFG_DISP_TMO:    n_cfg.disp_tmo    = i_cfg_data[31:0];
                CFG_WAKE_ERR:    n_cfg.wake_err    = i_cfg_data[0];
                CFG_WAKE_WARN:   n_cfg.wake_warn   = i_cfg_data[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motion_en   <= 1'b0;
            r_cfg.motion_thr  <= 16'd100;
            r_cfg.motion_cool <= 32'd3000;
            r_cfg.disp_tmo    <= 32'd30000;
            r_cfg.wake_err    <= 1'b1;
            r_cfg.wake_warn   <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

/* sv/dpm_evt_reg.sv */
// ----------------------------------------------------------------------------
// dpm_evt_reg
// input register for one event word
// ----------------------------------------------------------------------------
module dpm_evt_reg #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dpm_evt_if.sink               i_evt,
    input  logic                  i_take,
    output logic                  o_valid,
    output dpm_pkg::t_dpm_evt     o_evt,
    output logic [TIME_WIDTH-1:0] o_now
);
    import dpm_pkg::*;

    logic                  r_valid;
    t_dpm_evt              r_evt;
    logic [TIME_WIDTH-1:0] r_now;
    logic                  accept;

    // free when empty or when the held word moves on this cycle
    assign i_evt.ready = !r_valid || i_take;
    assign accept      = i_evt.valid && i_evt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_evt.command      <= t_dpm_cmd'(i_evt.command);
            r_evt.key_activity <= i_evt.key_activity;
            r_evt.motion_delta <= i_evt.motion_delta;
            r_evt.notify_level <= i_evt.notify_level;
            r_evt.quiet_mode   <= i_evt.quiet_mode;
            r_now              <= i_evt.timestamp;
        end
    end

    assign o_valid = r_valid;
    assign o_evt   = r_evt;
    assign o_now   = r_now;
endmodule

/* sv/dpm_core.sv */
// ----------------------------------------------------------------------------
// dpm_core
// mode state machine, motion qualifier and result register
// ----------------------------------------------------------------------------
module dpm_core #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dpm_pkg::t_dpm_cfg     i_cfg,
    input  logic                  i_valid,
    input  dpm_pkg::t_dpm_evt     i_evt,
    input  logic [TIME_WIDTH-1:0] i_now,
    output logic                  o_take,
    dpm_res_if.source             o_res
);
    import dpm_pkg::*;

    function automatic logic [TIME_WIDTH-1:0] sat_add(
        input logic [TIME_WIDTH-1:0] a,
        input logic [31:0]           b
    );
        logic [TIME_WIDTH:0] s;
        s = {1'b0, a} + {{(TIME_WIDTH - 31){1'b0}}, b};
        return s[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : s[TIME_WIDTH-1:0];
    endfunction

    t_dpm_mode             r_mode, n_mode;
    logic [TIME_WIDTH-1:0] r_last, n_last;
    logic [1:0]            r_cnt, n_cnt;
    logic [TIME_WIDTH-1:0] r_win_end, n_win_end;
    logic [TIME_WIDTH-1:0] r_cool_end, n_cool_end;
    logic                  r_out_valid;
    t_dpm_res              r_res, n_res;

    logic                  motion_hit;
    logic                  timeout_hit;
    logic                  notify_wake;
    logic [TIME_WIDTH-1:0] idle_time;

    assign o_take = i_valid && (!r_out_valid || o_res.ready);

    assign idle_time   = i_now - r_last;
    assign timeout_hit = (r_mode == MODE_ACTIVE) && (i_now >= r_last) &&
                         (idle_time >= TIME_WIDTH'(i_cfg.disp_tmo));
    assign notify_wake = ((i_evt.notify_level == LVL_ERROR) && i_cfg.wake_err) ||
                         ((i_evt.notify_level == LVL_WARN) && i_cfg.wake_warn);

    // timers and motion sample counter
    always_comb begin
        n_last     = r_last;
        n_cnt      = r_cnt;
        n_win_end  = r_win_end;
        n_cool_end = r_cool_end;
        motion_hit = 1'b0;
        case (i_evt.command)
            CMD_TICK: begin
                if (r_mode == MODE_DEEP) begin
                    if (i_evt.key_activity) begin
                        n_last = i_now;
                    end
                end else begin
                    if (i_cfg.motion_en && (i_now >= r_cool_end) &&
                        (i_evt.motion_delta != 16'd0)) begin
                        if (i_evt.motion_delta >= i_cfg.motion_thr) begin
                            if (i_now <= r_win_end) begin
                                n_cnt = (r_cnt < MOTION_SAMPLES) ? 2'(r_cnt + 2'd1) : r_cnt;
                            end else begin
                                n_cnt = 2'd1;
                            end
                            n_win_end  = sat_add(i_now, 32'(MOTION_WINDOW_MS));
                            motion_hit = (n_cnt >= MOTION_SAMPLES);
                        end else begin
                            n_cnt = 2'd0;
                        end
                    end
                    if (i_evt.key_activity || motion_hit) begin
                        n_cnt  = 2'd0;
                        n_last = i_now;
                        if (motion_hit) begin
                            n_cool_end = sat_add(i_now, i_cfg.motion_cool);
                        end
                    end else if (timeout_hit) begin
                        n_cnt = 2'd0;
                    end
                end
            end
            CMD_NOTIFY: begin
                if (notify_wake && (r_mode == MODE_ONLINE)) begin
                    n_last = i_now;
                end
            end
            CMD_DEEP_LEAVE: begin
                if (r_mode == MODE_DEEP) begin
                    n_last = i_now;
                end
            end
            default: begin
                n_last = r_last;
            end
        endcase
    end

    // next mode
    always_comb begin
        n_mode = r_mode;
        case (i_evt.command)
            CMD_TICK: begin
                if (r_mode == MODE_DEEP) begin
                    if (i_evt.key_activity) begin
                        n_mode = MODE_ACTIVE;
                    end
                end else if (i_evt.key_activity || motion_hit) begin
                    n_mode = MODE_ACTIVE;
                end else if (timeout_hit) begin
                    n_mode = MODE_ONLINE;
                end
            end
            CMD_NOTIFY: begin
                if (notify_wake && (r_mode == MODE_ONLINE)) begin
                    n_mode = MODE_ACTIVE;
                end
            end
            CMD_DEEP_ENTER: begin
                n_mode = MODE_DEEP;
            end
            CMD_DEEP_LEAVE: begin
                if (r_mode == MODE_DEEP) begin
                    n_mode = MODE_ACTIVE;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // action flags
    always_comb begin
        n_res              = '0;
        n_res.wake_src     = WAKE_NONE;
        n_res.current_mode = n_mode;
        case (i_evt.command)
            CMD_TICK: begin
                if (r_mode == MODE_DEEP) begin
                    if (i_evt.key_activity) begin
                        n_res.sleep_exit = 1'b1;
                        n_res.disp_on    = 1'b1;
                        n_res.wake_src   = WAKE_KEY;
                    end
                end else if (i_evt.key_activity || motion_hit) begin
                    if (r_mode == MODE_ONLINE) begin
                        n_res.disp_on  = 1'b1;
                        n_res.wake_src = motion_hit ? WAKE_MOTION : WAKE_KEY;
                    end
                end else if (timeout_hit) begin
                    n_res.disp_off = 1'b1;
                end
            end
            CMD_NOTIFY: begin
                n_res.sound_req = !i_evt.quiet_mode;
                if (notify_wake && (r_mode == MODE_ONLINE)) begin
                    n_res.disp_on  = 1'b1;
                    n_res.wake_src = WAKE_NOTIFY;
                end
            end
            CMD_DEEP_ENTER: begin
                if (r_mode != MODE_DEEP) begin
                    n_res.disp_off    = 1'b1;
                    n_res.sleep_enter = 1'b1;
                end
            end
            CMD_DEEP_LEAVE: begin
                if (r_mode == MODE_DEEP) begin
                    n_res.sleep_exit = 1'b1;
                    n_res.disp_on    = 1'b1;
                    n_res.wake_src   = WAKE_KEY;
                end
            end
            default: begin
                n_res.current_mode = n_mode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_ACTIVE;
            r_last     <= '0;
            r_cnt      <= 2'd0;
            r_win_end  <= '0;
            r_cool_end <= '0;
        end else if (o_take) begin
            r_mode     <= n_mode;
            r_last     <= n_last;
            r_cnt      <= n_cnt;
            r_win_end  <= n_win_end;
            r_cool_end <= n_cool_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.disp_on      = r_res.disp_on;
    assign o_res.disp_off     = r_res.disp_off;
    assign o_res.sleep_enter  = r_res.sleep_enter;
    assign o_res.sleep_exit   = r_res.sleep_exit;
    assign o_res.sound_req    = r_res.sound_req;
    assign o_res.wake_src     = r_res.wake_src;
    assign o_res.current_mode = r_res.current_mode;
endmodule

/* sv/display_power_mode_controller.sv */
// ----------------------------------------------------------------------------
// display_power_mode_controller
// three-mode display power controller: active, online standby, deep standby
// ----------------------------------------------------------------------------
//  channel   direction  handshake     contents
//  i_evt     in         valid/ready   command, timestamp, key, motion, notify
//  o_res     out        valid/ready   display/sleep/sound flags, wake reason, mode
//  i_cfg_*   in         write enable  register index and 32-bit write data
//
//  one event word per cycle sustained while the result side stays ready; a result
//  word is valid once its event word has passed the input register and then the
//  result register; a stall on the result side holds the word in the input register
//  the mode/timer state update sits in the single logic stage between the two
//  registers, so each event sees the state left by the one before it
//  a stalled result holds its register; the input register still takes one
//  more word, then ready drops until the result is taken
//  synchronous active-low reset restores the register defaults and active mode
// ----------------------------------------------------------------------------
module display_power_mode_controller #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dpm_evt_if.sink                         i_evt,
    dpm_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [dpm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dpm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dpm_pkg::*;

    t_dpm_cfg              cfg;
    logic                  evt_valid;
    t_dpm_evt              evt;
    logic [TIME_WIDTH-1:0] evt_now;
    logic                  evt_take;

    // configuration; the user must write it only while idle, the block does not enforce this
    dpm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // event word register, freed whenever the core takes its word
    dpm_evt_reg #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_evt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (i_evt),
        .i_take  (evt_take),
        .o_valid (evt_valid),
        .o_evt   (evt),
        .o_now   (evt_now)
    );

    // mode machine, motion qualifier, timeout compare and result register
    dpm_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (evt_valid),
        .i_evt   (evt),
        .i_now   (evt_now),
        .o_take  (evt_take),
        .o_res   (o_res)
    );
endmodule

/* dv/tb_display_power_mode_controller.sv */
// ----------------------------------------------------------------------------
// tb_display_power_mode_controller
// self-checking bench for the display power-mode controller
// ----------------------------------------------------------------------------
// drives event words through the valid/ready event channel and predicts the
// action flags of every event from a cycle-free model of the mode, timer and
// motion-qualification state. a scoreboard class keeps the expected flags in
// order and checks every result word field by field. a directed opening walks
// the mode transitions, notification levels, repeated requests and time
// saturation, then several register settings run random event streams with
// random idling on both sides and one long result-side hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_display_power_mode_controller;
    import dpm_pkg::*;

    localparam int TW           = 48;
    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 4;        // two-stage pipe plus margin
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 130;      // words sent before the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 76;
    localparam int PHASES       = 5;

    // register indexes past the end of the map, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    // notification level with no meaning of its own, acts like info
    localparam logic [1:0] LVL_INFO  = 2'd0;
    localparam logic [1:0] LVL_SPARE = 2'd3;

    typedef struct packed {
        t_dpm_evt      word;
        logic [TW-1:0] stamp;
    } t_power_event;

    // ------------------------------------------------------------------------
    // scoreboard: mode predictor plus the queue of expected flag words
    // ------------------------------------------------------------------------
    class power_flag_book;
        t_dpm_cfg      cfg;
        t_dpm_mode     mode;
        logic [TW-1:0] last_touch;
        logic [TW-1:0] window_end;
        logic [TW-1:0] cooldown_end;
        logic [1:0]    hits;
        t_dpm_res      expected_flags[$];
        int            errors;

        function new();
            cfg.motion_en   = 1'b0;
            cfg.motion_thr  = 16'd100;
            cfg.motion_cool = 32'd3000;
            cfg.disp_tmo    = 32'd30000;
            cfg.wake_err    = 1'b1;
            cfg.wake_warn   = 1'b0;
            mode            = MODE_ACTIVE;
            last_touch      = '0;
            window_end      = '0;
            cooldown_end    = '0;
            hits            = '0;
            errors          = 0;
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MOTION_EN:   cfg.motion_en   = data[0];
                CFG_MOTION_THR:  cfg.motion_thr  = data[15:0];
                CFG_MOTION_COOL: cfg.motion_cool = data;
                CFG_DISP_TMO:    cfg.disp_tmo    = data;
                CFG_WAKE_ERR:    cfg.wake_err    = data[0];
                CFG_WAKE_WARN:   cfg.wake_warn   = data[0];
                default: ;
            endcase
        endfunction

        // time sum clamped to the largest stamp
        function logic [TW-1:0] clamp_sum(logic [TW-1:0] a, logic [31:0] b);
            logic [TW:0] s;
            s = {1'b0, a} + b;
            return s[TW] ? {TW{1'b1}} : s[TW-1:0];
        endfunction

        function void leave_deep(logic [TW-1:0] stamp, ref t_dpm_res r);
            if (mode == MODE_DEEP) begin
                mode         = MODE_ACTIVE;
                last_touch   = stamp;
                r.wake_src   = WAKE_KEY;
                r.sleep_exit = 1'b1;
                r.disp_on    = 1'b1;
            end
        endfunction

        function void note_event(t_power_event e);
            t_dpm_res r;
            logic     moved;
            logic     wake;
            r     = '0;
            moved = 1'b0;
            case (e.word.command)
                CMD_TICK: begin
                    if (mode == MODE_DEEP) begin
                        if (e.word.key_activity)
                            leave_deep(e.stamp, r);
                    end else begin
                        if (cfg.motion_en && e.stamp >= cooldown_end &&
                            e.word.motion_delta != 16'd0) begin
                            if (e.word.motion_delta >= cfg.motion_thr) begin
                                if (e.stamp <= window_end) begin
                                    if (hits < MOTION_SAMPLES)
                                        hits = hits + 2'd1;
                                end else begin
                                    hits = 2'd1;
                                end
                                window_end = clamp_sum(e.stamp, 32'(MOTION_WINDOW_MS));
                                moved      = (hits >= MOTION_SAMPLES);
                            end else begin
                                hits = 2'd0;
                            end
                        end
                        if (e.word.key_activity || moved) begin
                            hits       = 2'd0;
                            last_touch = e.stamp;
                            if (moved)
                                cooldown_end = clamp_sum(e.stamp, cfg.motion_cool);
                            if (mode == MODE_ONLINE) begin
                                mode       = MODE_ACTIVE;
                                r.wake_src = moved ? WAKE_MOTION : WAKE_KEY;
                                r.disp_on  = 1'b1;
                            end
                        end else if (mode == MODE_ACTIVE && e.stamp >= last_touch &&
                                     e.stamp - last_touch >= cfg.disp_tmo) begin
                            mode       = MODE_ONLINE;
                            hits       = 2'd0;
                            r.disp_off = 1'b1;
                        end
                    end
                end
                CMD_NOTIFY: begin
                    wake = (e.word.notify_level == LVL_ERROR && cfg.wake_err) ||
                           (e.word.notify_level == LVL_WARN && cfg.wake_warn);
                    r.sound_req = !e.word.quiet_mode;
                    if (wake && mode == MODE_ONLINE) begin
                        mode       = MODE_ACTIVE;
                        last_touch = e.stamp;
                        r.wake_src = WAKE_NOTIFY;
                        r.disp_on  = 1'b1;
                    end
                end
                CMD_DEEP_ENTER: begin
                    if (mode != MODE_DEEP) begin
                        mode          = MODE_DEEP;
                        r.disp_off    = 1'b1;
                        r.sleep_enter = 1'b1;
                    end
                end
                default: leave_deep(e.stamp, r);
            endcase
            r.current_mode = mode;
            expected_flags.push_back(r);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_flags(t_dpm_res got);
            t_dpm_res want;
            if (expected_flags.size() == 0) begin
                $error("result word with no event outstanding");
                errors++;
                return;
            end
            want = expected_flags.pop_front();
            compare_field("disp_on", want.disp_on, got.disp_on);
            compare_field("disp_off", want.disp_off, got.disp_off);
            compare_field("sleep_enter", want.sleep_enter, got.sleep_enter);
            compare_field("sleep_exit", want.sleep_exit, got.sleep_exit);
            compare_field("sound_req", want.sound_req, got.sound_req);
            compare_field("wake_src", want.wake_src, got.wake_src);
            compare_field("current_mode", want.current_mode, got.current_mode);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, channels and the block
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dpm_evt_if #(.TIME_WIDTH(TW)) evt_ch ();
    dpm_res_if                    res_ch ();

    power_flag_book book;
    int             sent_words = 0;
    int             cycles     = 0;
    bit             calm       = 1'b0;  // no idling on either side while set
    logic           hold_res   = 1'b0;  // long result-side hold-off

    always #(HALF_PERIOD) i_clk = ~i_clk;

    display_power_mode_controller #(
        .TIME_WIDTH (TW)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // event side
    // ------------------------------------------------------------------------

    // offer one event word; valid stays high after the accept so that a
    // back-to-back word needs no second assignment in the same step
    task automatic offer_event(input t_power_event e);
        if (!calm && $urandom_range(99) < 30) begin
            evt_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 30);
        end
        evt_ch.valid        <= 1'b1;
        evt_ch.command      <= e.word.command;
        evt_ch.timestamp    <= e.stamp;
        evt_ch.key_activity <= e.word.key_activity;
        evt_ch.motion_delta <= e.word.motion_delta;
        evt_ch.notify_level <= e.word.notify_level;
        evt_ch.quiet_mode   <= e.word.quiet_mode;
        do @(posedge i_clk); while (!evt_ch.ready);
        book.note_event(e);
        sent_words++;
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_idle();
        evt_ch.valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write per cycle, only with the pipe empty
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        book.set_register(idx, data);
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic en, input logic [15:0] thr,
                                 input logic [31:0] cool, input logic [31:0] tmo,
                                 input logic err, input logic warn);
        wait_idle();
        write_register(CFG_MOTION_EN, {31'd0, en});
        write_register(CFG_MOTION_THR, {16'd0, thr});
        write_register(CFG_MOTION_COOL, cool);
        write_register(CFG_DISP_TMO, tmo);
        write_register(CFG_WAKE_ERR, {31'd0, err});
        write_register(CFG_WAKE_WARN, {31'd0, warn});
        // a write past the map must leave every register alone
        write_register(3'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)), $urandom);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_power_event make_event(t_dpm_cmd cmd, logic [TW-1:0] stamp,
                                                logic key, logic [15:0] delta,
                                                logic [1:0] lvl, logic quiet);
        t_power_event e;
        e.word.command      = cmd;
        e.word.key_activity = key;
        e.word.motion_delta = delta;
        e.word.notify_level = lvl;
        e.word.quiet_mode   = quiet;
        e.stamp             = stamp;
        return e;
    endfunction

    // random event: mostly ticks a few hundred ms apart so that motion pairs
    // land inside the window, with longer gaps for timeouts and rare jumps
    // backwards or anywhere in the time range
    function automatic t_power_event random_event(ref logic [TW-1:0] clk_ms);
        t_power_event e;
        int           roll;
        int           thr;
        thr  = book.cfg.motion_thr;
        roll = $urandom_range(99);
        if (roll < 65)
            clk_ms = clk_ms + $urandom_range(400);
        else if (roll < 80)
            clk_ms = clk_ms + $urandom_range(40000, 400);
        else if (roll < 90)
            clk_ms = clk_ms + $urandom;
        else if (roll < 95)
            clk_ms = clk_ms - $urandom_range(5000);
        else
            clk_ms = TW'({$urandom, $urandom});
        e.stamp = clk_ms;

        roll = $urandom_range(99);
        if (roll < 60)
            e.word.command = CMD_TICK;
        else if (roll < 78)
            e.word.command = CMD_NOTIFY;
        else if (roll < 89)
            e.word.command = CMD_DEEP_ENTER;
        else
            e.word.command = CMD_DEEP_LEAVE;

        // zero, below threshold, at or over threshold, anything
        roll = $urandom_range(99);
        if (roll < 25)
            e.word.motion_delta = 16'd0;
        else if (roll < 45 && thr > 1)
            e.word.motion_delta = 16'($urandom_range(thr - 1, 1));
        else if (roll < 90)
            e.word.motion_delta = 16'($urandom_range(16'hFFFF, thr));
        else
            e.word.motion_delta = 16'($urandom);

        e.word.key_activity = ($urandom_range(99) < 25);
        e.word.notify_level = 2'($urandom_range(3));
        e.word.quiet_mode   = 1'($urandom_range(1));
        return e;
    endfunction

    // ------------------------------------------------------------------------
    // result side: check each taken word, then pick the next ready
    // ------------------------------------------------------------------------
    initial begin
        t_dpm_res got;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.disp_on      = res_ch.disp_on;
                got.disp_off     = res_ch.disp_off;
                got.sleep_enter  = res_ch.sleep_enter;
                got.sleep_exit   = res_ch.sleep_exit;
                got.sound_req    = res_ch.sound_req;
                got.wake_src     = t_dpm_wake'(res_ch.wake_src);
                got.current_mode = t_dpm_mode'(res_ch.current_mode);
                book.check_flags(got);
            end
            if (hold_res)
                res_ch.ready <= 1'b0;
            else if (calm)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(99) >= 30);
        end
    end

    // long hold-off on the result side while events keep coming, so the
    // result register and the input register both fill and ready drops
    initial begin
        wait (sent_words >= HOLD_AT);
        @(posedge i_clk);
        hold_res <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_res <= 1'b0;
    end

    // watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [TW-1:0] clk_ms;
        logic [TW-1:0] top;
        book = new();

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= '0;
        i_cfg_data          <= '0;
        evt_ch.valid        <= 1'b0;
        evt_ch.command      <= CMD_TICK;
        evt_ch.timestamp    <= '0;
        evt_ch.key_activity <= 1'b0;
        evt_ch.motion_delta <= '0;
        evt_ch.notify_level <= '0;
        evt_ch.quiet_mode   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, reset register values ---
        // no timeout yet, then exactly the timeout
        offer_event(make_event(CMD_TICK, 48'd0, 1'b0, 16'd0, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_TICK, 48'd30000, 1'b0, 16'd0, LVL_INFO, 1'b0));
        // notification levels in online standby: info, warning (off), spare, error
        offer_event(make_event(CMD_NOTIFY, 48'd30001, 1'b0, 16'd0, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_NOTIFY, 48'd30002, 1'b0, 16'd0, LVL_WARN, 1'b1));
        offer_event(make_event(CMD_NOTIFY, 48'd30003, 1'b0, 16'd0, LVL_SPARE, 1'b0));
        offer_event(make_event(CMD_NOTIFY, 48'd30010, 1'b0, 16'd0, LVL_ERROR, 1'b1));
        // stamp behind the last interaction never times out
        offer_event(make_event(CMD_TICK, 48'd20, 1'b0, 16'hFFFF, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_TICK, 48'd60010, 1'b0, 16'd0, LVL_INFO, 1'b0));
        // key wake from online standby
        offer_event(make_event(CMD_TICK, 48'd60020, 1'b1, 16'd0, LVL_INFO, 1'b0));
        // deep standby: enter twice, idle tick, key tick leaves, leave while active, enter, leave
        offer_event(make_event(CMD_DEEP_ENTER, 48'd60030, 1'b0, 16'd0, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_DEEP_ENTER, 48'd60031, 1'b0, 16'd0, LVL_ERROR, 1'b0));
        offer_event(make_event(CMD_TICK, 48'd60032, 1'b0, 16'hFFFF, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_TICK, 48'd60040, 1'b1, 16'd0, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_DEEP_LEAVE, 48'd60041, 1'b0, 16'd0, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_DEEP_ENTER, 48'd60045, 1'b0, 16'd0, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_DEEP_LEAVE, 48'd60050, 1'b0, 16'd0, LVL_INFO, 1'b0));

        // --- directed motion at the top of the time range ---
        // largest threshold, cooldown and timeout; window and cooldown sums clamp
        apply_setting(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
        top = {TW{1'b1}};
        offer_event(make_event(CMD_TICK, top - 48'h1FF, 1'b0, 16'hFFFF, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_TICK, top - 48'hFF, 1'b0, 16'hFFFE, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_TICK, top - 48'hEF, 1'b0, 16'hFFFF, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_TICK, top - 48'hDF, 1'b0, 16'hFFFF, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_TICK, top - 48'hCF, 1'b0, 16'hFFFF, LVL_INFO, 1'b0));
        offer_event(make_event(CMD_NOTIFY, top, 1'b0, 16'd0, LVL_WARN, 1'b0));

        // --- random phases, one register setting each ---
        clk_ms = '0;
        for (int ph = 0; ph < PHASES; ph++) begin
            calm = 1'b0;
            case (ph)
                0: apply_setting(1'b1, 16'($urandom_range(500, 50)),
                                 $urandom_range(3000, 500), $urandom_range(5000, 1000),
                                 1'b1, 1'b1);
                // zero threshold and cooldown, no idling anywhere
                1: begin
                    apply_setting(1'b1, 16'd0, 32'd0, $urandom_range(3000, 200),
                                  1'b0, 1'b0);
                    calm = 1'b1;
                end
                // largest values near the top of the time range
                2: begin
                    apply_setting(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  1'b1, 1'b0);
                    clk_ms = {TW{1'b1}} - TW'($urandom_range(100000));
                end
                // motion off, immediate timeout
                3: apply_setting(1'b0, 16'($urandom), $urandom, 32'd0,
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
                default: apply_setting(1'($urandom_range(1)), 16'($urandom_range(1000)),
                                       $urandom_range(5000), $urandom_range(8000),
                                       1'($urandom_range(1)), 1'($urandom_range(1)));
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
                offer_event(random_event(clk_ms));
        end
        calm = 1'b0;

        wait_idle();
        if (book.errors == 0 && book.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* display_power_mode_controller.f */
sv/dpm_pkg.sv
sv/dpm_evt_if.sv
sv/dpm_res_if.sv
sv/dpm_cfg_regs.sv
sv/dpm_evt_reg.sv
sv/dpm_core.sv
sv/display_power_mode_controller.sv
dv/tb_display_power_mode_controller.sv
